/* rtl/addressable_led_pulse_encoder_assert.svh */
// assertion macros for the addressable led pulse encoder
// expects clk and rst_n in the scope of each use
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_ASSERT_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define ALED_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define ALED_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ALED_ASSERT_SAME(label, pre, post, msg)
`define ALED_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* rtl/aled_pkg.sv */
// shared types and constants of the addressable led pulse encoder
// no dependencies
`default_nettype none
package aled_pkg;

    localparam int MAX_LEDS   = 1024;
    localparam int LED_CNT_W  = 11;
    localparam int TICK_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int WORD_W     = 3 * COLOR_W;
    localparam int BIT_POS_W  = 5;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_LED_COUNT   = 2'd0,
        REG_SHORT_TICKS = 2'd1,
        REG_LONG_TICKS  = 2'd2,
        REG_RESET_TICKS = 2'd3
    } reg_index_t;

endpackage
`default_nettype wire

/* rtl/aled_in_if.sv */
// input channel of the encoder: one tick or start beat
// depends on aled_pkg
`default_nettype none
interface aled_in_if;
    import aled_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, command, red, green, blue, input ready);
    modport sink   (input valid, command, red, green, blue, output ready);
endinterface
`default_nettype wire

/* rtl/aled_out_if.sv */
// output channel of the encoder: one line sample beat per tick
// no dependencies beyond the language
`default_nettype none
interface aled_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, line_level, busy_res, frame_done, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface
`default_nettype wire

/* rtl/addressable_led_pulse_encoder.sv */
// addressable led data line pulse encoder, one line sample per input beat
// depends on aled_pkg, aled_in_if, aled_out_if and the assertion header
//
// channel  dir  beat contents
// cmd      in   command, red, green, blue
// wave     out  line_level, busy_res, frame_done
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// the state update for a tick is combinational and sits between the state
// registers and the output register, so a beat can be taken every cycle unless
// wave stalls: cmd.ready drops only while the output register is full and wave is stalled
// reset clears the state and loads the default tick counts and led count
`default_nettype none
`include "addressable_led_pulse_encoder_assert.svh"
module addressable_led_pulse_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    aled_in_if.sink                                cmd,
    aled_out_if.source                             wave,
    input  wire logic                              cfg_we,
    input  wire aled_pkg::reg_index_t              cfg_index,
    input  wire logic [aled_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aled_pkg::*;

    logic [LED_CNT_W-1:0] led_count_reg;
    logic [TICK_W-1:0]    short_ticks_reg;
    logic [TICK_W-1:0]    long_ticks_reg;
    logic [TICK_W-1:0]    reset_ticks_reg;

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [LED_CNT_W-1:0] leds_reg, leds_next;
    logic [WORD_W-1:0]    word_reg, word_next;

    logic out_valid_reg, out_valid_next;
    logic level_reg, level_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic                 in_acc;
    logic                 out_acc;
    logic                 start;
    phase_t               phase_eff;
    logic [TICK_W-1:0]    tick_eff;
    logic [TICK_W-1:0]    tick_dec;
    logic [BIT_POS_W-1:0] bit_pos_eff;
    logic [BIT_POS_W-1:0] bit_pos_inc;
    logic [LED_CNT_W-1:0] leds_eff;
    logic [LED_CNT_W-1:0] leds_inc;
    logic [LED_CNT_W-1:0] chain_len;
    logic [TICK_W-1:0]    short_eff;
    logic [TICK_W-1:0]    long_eff;
    logic [TICK_W-1:0]    reset_eff;
    logic                 cur_bit;
    logic                 next_bit;
    logic [WORD_W-1:0]    start_word;

    assign in_acc    = cmd.valid && cmd.ready;
    assign out_acc   = wave.valid && wave.ready;
    assign cmd.ready = !out_valid_reg || wave.ready;

    assign wave.valid      = out_valid_reg;
    assign wave.line_level = level_reg;
    assign wave.busy_res   = busy_reg;
    assign wave.frame_done = done_reg;

    // zero counts act as one, led count clipped to the chain limit
    assign short_eff = (short_ticks_reg == '0) ? TICK_W'(1) : short_ticks_reg;
    assign long_eff  = (long_ticks_reg == '0) ? TICK_W'(1) : long_ticks_reg;
    assign reset_eff = (reset_ticks_reg == '0) ? TICK_W'(1) : reset_ticks_reg;

    always_comb
    begin
        if (led_count_reg == '0)
        begin
            chain_len = LED_CNT_W'(1);
        end
        else if (led_count_reg > LED_CNT_W'(MAX_LEDS))
        begin
            chain_len = LED_CNT_W'(MAX_LEDS);
        end
        else
        begin
            chain_len = led_count_reg;
        end
    end

    assign start      = (phase_reg == PH_IDLE) && cmd.command;
    assign start_word = {cmd.green, cmd.red, cmd.blue};

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_pos_next = bit_pos_reg;
        leds_next    = leds_reg;
        word_next    = word_reg;
        level_next   = 1'b0;
        busy_next    = 1'b0;
        done_next    = 1'b0;

        // a start beat is already the first high tick of the first bit
        if (start)
        begin
            word_next   = start_word;
            phase_eff   = PH_HIGH;
            bit_pos_eff = '0;
            leds_eff    = '0;
            tick_eff    = start_word[WORD_W-1] ? long_eff : short_eff;
        end
        else
        begin
            phase_eff   = phase_reg;
            bit_pos_eff = bit_pos_reg;
            leds_eff    = leds_reg;
            tick_eff    = tick_reg;
        end

        cur_bit  = word_next[BIT_POS_W'(WORD_W - 1) - bit_pos_eff];
        tick_dec = (tick_eff == '0) ? '0 : tick_eff - TICK_W'(1);

        // advance to the next bit, wrapping into the next led
        if (bit_pos_eff == BIT_POS_W'(WORD_W - 1))
        begin
            bit_pos_inc = '0;
            leds_inc    = leds_eff + LED_CNT_W'(1);
        end
        else
        begin
            bit_pos_inc = bit_pos_eff + BIT_POS_W'(1);
            leds_inc    = leds_eff;
        end
        next_bit = word_next[BIT_POS_W'(WORD_W - 1) - bit_pos_inc];

        if (phase_eff != PH_IDLE)
        begin
            busy_next    = 1'b1;
            level_next   = (phase_eff == PH_HIGH);
            phase_next   = phase_eff;
            bit_pos_next = bit_pos_eff;
            leds_next    = leds_eff;
            tick_next    = tick_dec;
            if (tick_dec == '0)
            begin
                unique case (phase_eff)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        tick_next  = cur_bit ? short_eff : long_eff;
                    end
                    PH_LOW:
                    begin
                        bit_pos_next = bit_pos_inc;
                        leds_next    = leds_inc;
                        if (leds_inc >= chain_len)
                        begin
                            phase_next = PH_LATCH;
                            tick_next  = reset_eff;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            tick_next  = next_bit ? long_eff : short_eff;
                        end
                    end
                    PH_LATCH:
                    begin
                        done_next    = 1'b1;
                        phase_next   = PH_IDLE;
                        bit_pos_next = '0;
                        leds_next    = '0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (in_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= LED_CNT_W'(1);
            short_ticks_reg <= TICK_W'(60);
            long_ticks_reg  <= TICK_W'(180);
            reset_ticks_reg <= TICK_W'(6000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LED_COUNT:   led_count_reg   <= cfg_data[LED_CNT_W-1:0];
                REG_SHORT_TICKS: short_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_LONG_TICKS:  long_ticks_reg  <= cfg_data[TICK_W-1:0];
                REG_RESET_TICKS: reset_ticks_reg <= cfg_data[TICK_W-1:0];
                default:         led_count_reg   <= led_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_pos_reg   <= '0;
            leds_reg      <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                bit_pos_reg <= bit_pos_next;
                leds_reg    <= leds_next;
                word_reg    <= word_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            level_reg <= level_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    `ALED_ASSERT_SAME(a_bit_pos_range, 1'b1, bit_pos_reg < BIT_POS_W'(WORD_W), "bit position past word")
    `ALED_ASSERT_SAME(a_leds_range, 1'b1, leds_reg <= LED_CNT_W'(MAX_LEDS), "led count past limit")
    `ALED_ASSERT_SAME(a_tick_live, phase_reg != PH_IDLE, tick_reg != '0, "active phase with no ticks")
    `ALED_ASSERT_SAME(a_out_busy, out_valid_reg && (level_reg || done_reg), busy_reg, "line activity while not busy")
    `ALED_ASSERT_NEXT(a_idle_tick, in_acc && phase_reg == PH_IDLE && !cmd.command, phase_reg == PH_IDLE, "plain tick left idle")

endmodule
`default_nettype wire
